FILE: design/csvfe_pkg.sv
// ----------------------------------------------------------------------------
// csvfe_pkg
// Shared types and character constants for the CSV cell escaper.
// ----------------------------------------------------------------------------
package csvfe_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        SEL_QUOTE = 2'd0,
        SEL_BYTE  = 2'd1,
        SEL_SEP   = 2'd2
    } out_sel_t;

    typedef struct packed {
        logic     take;
        logic     emit;
        out_sel_t sel;
        logic     advance;
        logic     clear_cell;
    } cmd_t;

    typedef struct packed {
        logic quote_needed;
        logic body_done;
        logic cur_is_quote;
        logic out_free;
    } sts_t;

    function automatic logic forces_quote(input logic [7:0] b);
        return (b == CH_COMMA) || (b == CH_QUOTE) || (b == CH_CR) || (b == CH_LF);
    endfunction

endpackage

FILE: design/csv_row_field_escaper_core.sv
// ----------------------------------------------------------------------------
// csv_row_field_escaper_core
// RFC 4180 style CSV cell quoting with a bounded cell buffer.
//
// Input channel (in_valid/in_ready): one beat per cell byte; has_byte low
// marks a beat with no byte, cell_end closes the cell, row_end picks a
// newline instead of a comma as separator. Output channel
// (out_valid/out_ready): one escaped byte per beat, last on the separator,
// overflow on every beat of a cell that lost bytes past CELL_BYTES.
// A beat without cell_end is taken while the input stays open. A closing
// beat starts the output walk: the sequencer emits at most one byte per
// cycle from the cell buffer through a single output register, with idle
// steps that emit nothing (open without quotes, end of body). Input is
// held off for the whole walk; the final separator may still wait in the
// output register while the next cell's beats come in. A stalled receiver
// freezes the walk.
// Reset clears the fill count, flags, sequencer and output valid.
// ----------------------------------------------------------------------------
module csv_row_field_escaper_core
    import csvfe_pkg::*;
#(
    parameter int CELL_BYTES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       cell_end,
    input  logic       row_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       overflow
);

    cmd_t cmd;
    sts_t sts;

    csvfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cell_end (cell_end),
        .sts      (sts),
        .cmd      (cmd)
    );

    csvfe_dp #(
        .CELL_BYTES (CELL_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .cell_end  (cell_end),
        .row_end   (row_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last),
        .overflow  (overflow)
    );

    a_close_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cell_end |=> !in_ready)
        else $error("input still open after a closing beat");

    a_sep_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (out_byte == CH_LF) || (out_byte == CH_COMMA))
        else $error("separator beat carries a non-separator byte");

    a_idle_holds_only_sep: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last)
        else $error("input open while a cell body beat is pending");

endmodule

FILE: design/csvfe_dp.sv
// ----------------------------------------------------------------------------
// csvfe_dp
// Cell buffer, fill and read pointers, quoting flags and output register.
// ----------------------------------------------------------------------------
module csvfe_dp
    import csvfe_pkg::*;
#(
    parameter int CELL_BYTES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       cell_end,
    input  logic       row_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       overflow
);

    localparam int CNT_W = $clog2(CELL_BYTES + 1);
    localparam int IDX_W = (CELL_BYTES > 1) ? $clog2(CELL_BYTES) : 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(CELL_BYTES);

    logic [7:0]       buf_reg [CELL_BYTES];
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             quote_reg, quote_next;
    logic             trunc_reg, trunc_next;
    logic             row_reg, row_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             last_reg, last_next;
    logic             overflow_reg, overflow_next;
    logic [7:0]       cur_byte;
    logic             store;

    assign store    = cmd.take && has_byte && (fill_reg < FULL);
    assign cur_byte = buf_reg[rd_ptr_reg[IDX_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            buf_reg[fill_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        quote_next     = quote_reg;
        trunc_next     = trunc_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        overflow_next  = overflow_reg;

        if (cmd.take)
        begin
            if (store)
            begin
                fill_next  = fill_reg + CNT_W'(1);
                quote_next = quote_reg | forces_quote(data_byte);
            end
            else if (has_byte)
            begin
                trunc_next = 1'b1;
            end
            if (cell_end)
            begin
                row_next    = row_end;
                rd_ptr_next = '0;
            end
        end

        if (cmd.advance)
        begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            overflow_next  = trunc_reg;
            last_next      = 1'b0;
            unique case (cmd.sel)
                SEL_QUOTE: out_byte_next = CH_QUOTE;
                SEL_BYTE:  out_byte_next = cur_byte;
                SEL_SEP:
                begin
                    out_byte_next = row_reg ? CH_LF : CH_COMMA;
                    last_next     = 1'b1;
                end
                default:   out_byte_next = CH_QUOTE;
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.clear_cell)
        begin
            fill_next  = '0;
            quote_next = 1'b0;
            trunc_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            quote_reg     <= 1'b0;
            trunc_reg     <= 1'b0;
            row_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rd_ptr_reg    <= rd_ptr_next;
            quote_reg     <= quote_next;
            trunc_reg     <= trunc_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        overflow_reg <= overflow_next;
    end

    assign sts.quote_needed = quote_reg;
    assign sts.body_done    = (rd_ptr_reg == fill_reg);
    assign sts.cur_is_quote = (cur_byte == CH_QUOTE);
    assign sts.out_free     = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign overflow  = overflow_reg;

endmodule

FILE: design/csvfe_ctrl.sv
// ----------------------------------------------------------------------------
// csvfe_ctrl
// Sequencer: takes cell beats, then walks the escaped output of a closed cell.
// ----------------------------------------------------------------------------
module csvfe_ctrl
    import csvfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic cell_end,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_OPEN   = 6'b000010,
        ST_BODY   = 6'b000100,
        ST_BODY_Q = 6'b001000,
        ST_CLOSE  = 6'b010000,
        ST_SEP    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.take       = 1'b0;
        cmd.emit       = 1'b0;
        cmd.sel        = SEL_BYTE;
        cmd.advance    = 1'b0;
        cmd.clear_cell = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid && cell_end)
                begin
                    state_next = ST_OPEN;
                end
            end
            ST_OPEN:
            begin
                if (!sts.quote_needed)
                begin
                    state_next = ST_BODY;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_QUOTE;
                    state_next = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (sts.body_done)
                begin
                    state_next = sts.quote_needed ? ST_CLOSE : ST_SEP;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.quote_needed && sts.cur_is_quote)
                    begin
                        cmd.sel    = SEL_QUOTE;
                        state_next = ST_BODY_Q;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            ST_BODY_Q:
            begin
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.advance = 1'b1;
                    state_next  = ST_BODY;
                end
            end
            ST_CLOSE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_QUOTE;
                    state_next = ST_SEP;
                end
            end
            ST_SEP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.sel        = SEL_SEP;
                    cmd.clear_cell = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule
